// ===== rtl/pod_pkg.sv =====
// Package for the PPS oscillator discipline block.
// Holds the input and result word types, event codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pod_pkg;

	typedef enum logic [1:0] {
		ACT_OSC  = 2'd0,
		ACT_SYS  = 2'd1,
		ACT_PPS  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_WRAP    = 2'd0,
		REG_WINDOW  = 2'd1,
		REG_TIMEOUT = 2'd2,
		REG_NONE    = 2'd3
	} reg_index_t;

	localparam logic [31:0] WRAP_RESET    = 32'd99999;
	localparam logic [6:0]  WINDOW_RESET  = 7'd99;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1001;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic               locked;
		logic               tick_led;
		logic               pps_led;
		logic signed [31:0] ppm_tenths;
		logic signed [31:0] error_sum;
		logic [31:0]        phase_count;
		logic [6:0]         window_pos;
	} out_word_t;

endpackage

`default_nettype wire

// ===== rtl/pod_core.sv =====
// State and event logic of the PPS oscillator discipline block.
// Updates the phase, lock and error state for one event per cycle, on each cycle that fire is high.
// Depends on pod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pod_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire pod_pkg::in_word_t word,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	output pod_pkg::out_word_t     result
);
	import pod_pkg::*;

	logic [31:0] wrap_q;
	logic [6:0]  window_last_q;
	logic [15:0] timeout_q;

	logic [31:0] phase_q, cap_q, err_q, tot_q, ppm_q, last_q;
	logic [6:0]  window_q;
	logic        lock_q, tick_led_q, pps_led_q;

	logic [31:0] phase_n, cap_n, err_n, tot_n, ppm_n, last_n;
	logic [6:0]  window_n;
	logic        lock_n, tick_led_n, pps_led_n;

	logic [31:0] phase_inc, elapsed, tot_sum, t_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q        <= WRAP_RESET;
			window_last_q <= WINDOW_RESET;
			timeout_q     <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_WRAP:    wrap_q        <= cfg_data;
				REG_WINDOW:  window_last_q <= cfg_data[6:0];
				REG_TIMEOUT: timeout_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_inc = phase_q + 32'd1;
		elapsed   = word.now_ms - last_q;
		tot_sum   = tot_q + err_q;
		t_val     = phase_q - tot_sum;

		phase_n    = phase_q;
		cap_n      = cap_q;
		err_n      = err_q;
		tot_n      = tot_q;
		ppm_n      = ppm_q;
		last_n     = last_q;
		window_n   = window_q;
		lock_n     = lock_q;
		tick_led_n = tick_led_q;
		pps_led_n  = pps_led_q;

		unique case (action_t'(word.action))
			ACT_OSC: begin
				if (phase_inc >= wrap_q) begin
					phase_n    = '0;
					tick_led_n = ~tick_led_q;
				end else begin
					phase_n = phase_inc;
				end
			end
			ACT_SYS: begin
				if (elapsed < {16'd0, timeout_q}) begin
					lock_n = 1'b1;
				end else begin
					lock_n = 1'b0;
					cap_n  = '0;
					ppm_n  = '0;
				end
			end
			ACT_PPS: begin
				last_n = word.now_ms;
				if (lock_q) begin
					pps_led_n = ~pps_led_q;
					priority if (cap_q == 32'd0) begin
						cap_n = phase_q;
					end else if (window_q >= window_last_q) begin
						tot_n    = tot_sum;
						ppm_n    = err_q;
						window_n = '0;
						err_n    = t_val - cap_q - 32'd1;
						cap_n    = t_val;
						phase_n  = t_val;
					end else begin
						window_n = window_q + 7'd1;
						err_n    = err_q + phase_q - cap_q - 32'd1;
						cap_n    = phase_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			cap_q      <= '0;
			err_q      <= '0;
			tot_q      <= '0;
			ppm_q      <= '0;
			last_q     <= '0;
			window_q   <= '0;
			lock_q     <= 1'b0;
			tick_led_q <= 1'b0;
			pps_led_q  <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_n;
			cap_q      <= cap_n;
			err_q      <= err_n;
			tot_q      <= tot_n;
			ppm_q      <= ppm_n;
			last_q     <= last_n;
			window_q   <= window_n;
			lock_q     <= lock_n;
			tick_led_q <= tick_led_n;
			pps_led_q  <= pps_led_n;
		end
	end

	always_comb begin
		result.locked      = lock_n;
		result.tick_led    = tick_led_n;
		result.pps_led     = pps_led_n;
		result.ppm_tenths  = $signed(ppm_n);
		result.error_sum   = $signed(err_n);
		result.phase_count = phase_n;
		result.window_pos  = window_n;
	end

`ifndef SYNTHESIS
	a_window_only_on_pps: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && word.action == ACT_PPS) |=> $stable(window_q))
		else $error("window count changed without a PPS edge");
	a_tick_led_only_on_osc: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && word.action == ACT_OSC) |=> $stable(tick_led_q))
		else $error("tick LED changed without an oscillator tick");
	a_lock_loss_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.action == ACT_SYS && elapsed >= {16'd0, timeout_q}
		|=> !lock_q && cap_q == 32'd0 && ppm_q == 32'd0)
		else $error("lock loss did not clear capture and ppm");
`endif

endmodule

`default_nettype wire

// ===== rtl/pod_skid.sv =====
// Output register with a skid stage for result words.
// Keeps the input side free while one result waits in the output register; free drops while the skid stage is full.
// Depends on pod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pod_skid (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire pod_pkg::out_word_t in_word,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pod_pkg::out_word_t      out_word
);
	import pod_pkg::*;

	logic      main_valid_q, skid_valid_q;
	out_word_t main_q, skid_q;

	assign free      = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !main_valid_q) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : in_word;
		end
		if (in_fire && main_valid_q && !out_ready) begin
			skid_q <= in_word;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid stage full while output register empty");
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(main_valid_q && !out_ready && in_fire))
		else $error("skid stage filled without a stalled output");
`endif

endmodule

`default_nettype wire

// ===== rtl/pps_oscillator_discipline.sv =====
// PPS oscillator discipline block: phase counter, lock and error window.
// The result word of an accepted event is registered in pod_skid before it appears on the output.
// Throughput: one event per cycle while in_ready is high; in_ready drops while the skid stage is full.
// The skid stage in pod_skid lets one more event in while a result waits.
// Reset clears the core state and the output valid flags and loads the default wrap limit, window and timeout.
`timescale 1ns / 1ps
`default_nettype none

module pps_oscillator_discipline (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pod_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pod_pkg::out_word_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import pod_pkg::*;

	logic      fire;
	out_word_t result;

	assign fire = in_valid && in_ready;

	pod_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	pod_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (fire),
		.in_word   (result),
		.free      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_data)
	);

endmodule

`default_nettype wire
